FILE: design/slph_pkg.sv
// Package for the sliced linear-probe hash set: command codes, the hash multiplier, the reset table size.
// No dependencies; every design file imports it.
package slph_pkg;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [63:0] MIX_MUL = 64'h9ae16a3b2f904053;

  localparam int LOG_SLOTS_RESET = 7;

endpackage

FILE: design/slph_front.sv
// Front end: accepts a command word and hashes its key in a multi-step mixer, one word at a time.
// Uses slph_pkg. Each of the three 64-bit products is built from 32x32 partial products.
module slph_front #(
  parameter int KEY_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                hv_valid,
  input  logic                hv_ready,
  output logic                hv_cmd,
  output logic [KEY_BITS-1:0] hv_key,
  output logic [63:0]         hv_hash
);
  import slph_pkg::*;

  // Stage machine: one item at a time through three multiply steps.
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SUM  = 4'b0100,
    F_DONE = 4'b1000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [1:0]        mul_idx_r, mul_idx_nxt;
  logic              cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [63:0]       v_r, x_r;
  logic [63:0]       pp_lo_r, pp_mid_r;
  logic [63:0]       hash_r;

  logic [63:0] v_in, u_in, mixed, b_fin;
  logic [63:0] prod;

  assign v_in = {32'd0, in_key[31:0]} ^ ({32'd0, in_key[31:0]} << 35);
  assign u_in = 64'd4 + (v_in << 3);

  // Low product and cross terms; only 64 low bits of the product matter.
  assign prod = pp_lo_r + {pp_mid_r[31:0], 32'd0};

  assign b_fin = prod ^ {prod[46:0], prod[63:47]} ^ {prod[34:0], prod[63:35]};
  assign mixed = prod ^ (prod >> 47);

  always_comb begin
    state_nxt   = state_r;
    mul_idx_nxt = mul_idx_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUM;
      F_SUM: begin
        if (mul_idx_r == 2'd2) begin
          state_nxt = F_DONE;
        end else begin
          mul_idx_nxt = mul_idx_r + 2'd1;
          state_nxt   = F_MUL;
        end
      end
      F_DONE: if (hv_ready) begin
        state_nxt   = F_IDLE;
        mul_idx_nxt = 2'd0;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      mul_idx_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      mul_idx_r <= mul_idx_nxt;
    end
  end

  // Hold operands, form partial products and fold each product into the next operand or the hash.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      v_r   <= v_in;
      x_r   <= u_in ^ v_in;
    end
    if (state_r == F_MUL) begin
      pp_lo_r  <= 64'(x_r[31:0]) * 64'(MIX_MUL[31:0]);
      pp_mid_r <= 64'(32'(x_r[31:0] * MIX_MUL[63:32]) + 32'(x_r[63:32] * MIX_MUL[31:0]));
    end
    if (state_r == F_SUM) begin
      case (mul_idx_r)
        2'd0:    x_r <= v_r ^ mixed;
        2'd1:    x_r <= mixed;
        default: hash_r <= b_fin;
      endcase
    end
  end

  assign in_ready = (state_r == F_IDLE);
  assign hv_valid = (state_r == F_DONE);
  assign hv_cmd   = cmd_r;
  assign hv_key   = key_r;
  assign hv_hash  = hash_r;

endmodule

FILE: design/slph_queue.sv
// Two-entry queue between the hashing front end and the probing back end.
// Uses slph_pkg for nothing beyond the common import convention.
module slph_queue #(
  parameter int WIDTH = 113
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import slph_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: design/slph_back.sv
// Back end: linear probe over the key memory with per-slot valid bits.
// Uses slph_pkg. Clears the valid memory after reset, one slot a cycle.
module slph_back #(
  parameter int SLICE_COUNT   = 4,
  parameter int MAX_LOG_SLOTS = 12,
  parameter int KEY_BITS      = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          log_slots,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic                q_cmd,
  input  logic [KEY_BITS-1:0] q_key,
  input  logic [63:0]         q_hash,
  output logic                r_valid,
  input  logic                r_ready,
  output logic                r_found,
  output logic                r_inserted,
  output logic                r_full,
  output logic [1:0]          r_slice,
  output logic [11:0]         r_slot,
  output logic [12:0]         r_count
);
  import slph_pkg::*;

  localparam int SLICE_BITS = (SLICE_COUNT > 1) ? $clog2(SLICE_COUNT) : 1;
  localparam int ADDR_BITS  = SLICE_BITS + MAX_LOG_SLOTS;
  localparam int DEPTH      = SLICE_COUNT << MAX_LOG_SLOTS;
  localparam int CNT_BITS   = MAX_LOG_SLOTS + 1;

  typedef enum logic [5:0] {
    B_CLEAR = 6'b000001,
    B_IDLE  = 6'b000010,
    B_READ  = 6'b000100,
    B_CHECK = 6'b001000,
    B_OUT   = 6'b010000,
    B_WAIT  = 6'b100000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [KEY_BITS-1:0]      key_mem [DEPTH];
  logic                     vld_mem [DEPTH];
  logic [KEY_BITS-1:0]      rd_key_r;
  logic                     rd_vld_r;

  logic [ADDR_BITS-1:0]     clr_r;
  logic                     cmd_r;
  logic [KEY_BITS-1:0]      key_r;
  logic [SLICE_BITS-1:0]    slice_r;
  logic [MAX_LOG_SLOTS-1:0] start_r, pos_r, mask_r;
  logic [CNT_BITS-1:0]      cnt_r, size_r;
  logic                     found_r, ins_r, full_r;

  logic [3:0]               lg;
  logic [SLICE_BITS-1:0]    slice_in;
  logic [MAX_LOG_SLOTS-1:0] mask_in;
  logic [ADDR_BITS-1:0]     addr;
  logic                     wr_en;
  logic [SLICE_BITS-1:0]    slice_raw;

  // Clamp the size register and pick the slice.
  always_comb begin
    lg = log_slots;
    if (lg < 4'd1) lg = 4'd1;
    if (32'(lg) > MAX_LOG_SLOTS) lg = 4'(MAX_LOG_SLOTS);
    mask_in   = MAX_LOG_SLOTS'(({{CNT_BITS{1'b0}}, 1'b1} << lg) - 1'b1);
    slice_raw = SLICE_BITS'((q_key[SLICE_BITS-1+32:32]) ^ q_hash[SLICE_BITS-1+32:32]);
    // Masking with SLICE_COUNT-1 always lands below SLICE_COUNT.
    slice_in  = slice_raw & SLICE_BITS'(SLICE_COUNT - 1);
  end

  assign addr  = (state_r == B_CLEAR) ? clr_r : {slice_r, pos_r};
  assign wr_en = (state_r == B_CHECK) && !rd_vld_r && cmd_r && !full_r
                 && (cnt_r < size_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_r == ADDR_BITS'(DEPTH - 1)) state_nxt = B_IDLE;
      B_IDLE:  if (q_valid) state_nxt = B_READ;
      B_READ:  state_nxt = (cnt_r >= size_r) ? B_OUT : B_WAIT;
      B_WAIT:  state_nxt = B_CHECK;
      B_CHECK: state_nxt = (!rd_vld_r || rd_key_r == key_r) ? B_OUT : B_READ;
      B_OUT:   if (r_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  // Memory: registered read, single write port for each array.
  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[addr];
    rd_vld_r <= vld_mem[addr];
    if (state_r == B_CLEAR) vld_mem[addr] <= 1'b0;
    else if (wr_en)        vld_mem[addr] <= 1'b1;
    if (wr_en) key_mem[addr] <= key_r;
  end

  // Probe bookkeeping.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (q_valid) begin
        cmd_r   <= q_cmd;
        key_r   <= q_key;
        slice_r <= slice_in;
        mask_r  <= mask_in;
        start_r <= q_hash[MAX_LOG_SLOTS-1:0] & mask_in;
        pos_r   <= q_hash[MAX_LOG_SLOTS-1:0] & mask_in;
        size_r  <= {1'b0, mask_in} + 1'b1;
        cnt_r   <= '0;
        found_r <= 1'b0;
        ins_r   <= 1'b0;
        full_r  <= 1'b0;
      end
      B_READ: if (cnt_r >= size_r) begin
        full_r <= 1'b1;
        pos_r  <= start_r;
      end
      B_CHECK: begin
        if (!rd_vld_r) begin
          ins_r <= cmd_r;
        end else if (rd_key_r == key_r) begin
          found_r <= 1'b1;
        end else begin
          pos_r <= (pos_r + 1'b1) & mask_r;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign q_ready    = (state_r == B_IDLE);
  assign r_valid    = (state_r == B_OUT);
  assign r_found    = found_r;
  assign r_inserted = ins_r;
  assign r_full     = full_r;
  assign r_slice    = 2'(slice_r);
  assign r_slot     = 12'(pos_r);
  assign r_count    = 13'(cnt_r);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid |-> !(r_found && r_inserted)) else $error("found and inserted together");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (r_valid && r_full) |-> (!r_found && !r_inserted)) else $error("full with hit");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cmd_r) else $error("write on lookup");

endmodule

FILE: design/sliced_linear_probe_hash_set.sv
// Sliced linear-probe hash set, top level: front hasher, queue, probing back end.
// Path: hasher (mul and sum steps per product), queue, back end (read, wait, check, out);
// read, wait, check repeat per slot passed. Hasher and back end each hold one word at a time.
// Reset (rst_n, synchronous): valid bits of all SLICE_COUNT*2^MAX_LOG_SLOTS slots are swept clear,
// and the back end takes no word until the sweep ends; the size register log_r returns to 7.
module sliced_linear_probe_hash_set #(
  parameter int SLICE_COUNT   = 4,
  parameter int MAX_LOG_SLOTS = 12,
  parameter int KEY_BITS      = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [((KEY_BITS+7)/8)*8-1:0] in_tdata,  // key
  input  logic          in_tuser,  // cmd
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata  // found, inserted, slice_full, slice_number, slot_index, probe_count
);
  import slph_pkg::*;

  localparam int QW = 1 + KEY_BITS + 64;

  logic [3:0]          log_r;
  logic                hv_valid, hv_ready, hv_cmd;
  logic [KEY_BITS-1:0] hv_key;
  logic [63:0]         hv_hash;
  logic                q_valid, q_ready;
  logic [QW-1:0]       q_data;
  logic                found, ins, full;
  logic [1:0]          slice;
  logic [11:0]         slot;
  logic [12:0]         cnt;

  // Hold the size register.
  always_ff @(posedge clk) begin
    if (!rst_n)      log_r <= 4'(LOG_SLOTS_RESET);
    else if (cfg_we) log_r <= cfg_wdata;
  end

  slph_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser), .in_key(in_tdata[KEY_BITS-1:0]),
    .hv_valid, .hv_ready, .hv_cmd, .hv_key, .hv_hash
  );

  slph_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n,
    .wr_valid(hv_valid), .wr_ready(hv_ready), .wr_data({hv_cmd, hv_key, hv_hash}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  slph_back #(.SLICE_COUNT(SLICE_COUNT), .MAX_LOG_SLOTS(MAX_LOG_SLOTS),
              .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n, .log_slots(log_r),
    .q_valid, .q_ready,
    .q_cmd(q_data[QW-1]), .q_key(q_data[QW-2:64]), .q_hash(q_data[63:0]),
    .r_valid(out_tvalid), .r_ready(out_tready),
    .r_found(found), .r_inserted(ins), .r_full(full),
    .r_slice(slice), .r_slot(slot), .r_count(cnt)
  );

  assign out_tdata = {2'd0, cnt, slot, slice, full, ins, found};

endmodule
